/* rtl/core/png_ru_pkg.sv */
// Shared types and constants for the image row unfilter block.
package png_ru_pkg;

    localparam int BPP_W     = 4;
    localparam int BPP_RESET = 4;

    // Row filter codes
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    typedef struct packed {
        logic [7:0] filtered_byte;
        logic [2:0] filter_type;
        logic       last_in_row;
        logic       above_is_zero;
    } t_in_item;

    typedef struct packed {
        logic [7:0] recon_byte;
        logic       row_done;
    } t_out_item;

    // Operands of the predictor: filtered byte plus left, above, above-left.
    typedef struct packed {
        logic [7:0] filtered_byte;
        logic [2:0] filter_type;
        logic [7:0] left;
        logic [7:0] above;
        logic [7:0] above_left;
    } t_pred_in;

endpackage

/* rtl/core/png_ru_line_store.sv */
// Single-port-read, single-port-write line store holding the prior reconstructed row.
module png_ru_line_store #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data held while no read is issued (downstream stall).
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/png_ru_predict.sv */
// Predictor selection and modulo-256 reconstruction for one byte.
module png_ru_predict (
    input  png_ru_pkg::t_pred_in i_op,
    output logic [7:0]           o_recon
);
    import png_ru_pkg::*;

    logic [8:0] sum_ab;
    logic [8:0] two_c;
    logic [7:0] pa;
    logic [7:0] pb;
    logic [8:0] pc;
    logic [7:0] paeth;
    logic [7:0] pred;

    assign sum_ab = {1'b0, i_op.left} + {1'b0, i_op.above};
    assign two_c  = {i_op.above_left, 1'b0};

    // |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    assign pa = (i_op.above > i_op.above_left) ? i_op.above - i_op.above_left
                                               : i_op.above_left - i_op.above;
    assign pb = (i_op.left > i_op.above_left) ? i_op.left - i_op.above_left
                                              : i_op.above_left - i_op.left;
    assign pc = (sum_ab > two_c) ? sum_ab - two_c : two_c - sum_ab;

    always_comb begin
        if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
            paeth = i_op.left;
        end else if ({1'b0, pb} <= pc) begin
            paeth = i_op.above;
        end else begin
            paeth = i_op.above_left;
        end
    end

    always_comb begin
        case (i_op.filter_type)
            FILT_SUB:   pred = i_op.left;
            FILT_UP:    pred = i_op.above;
            FILT_AVG:   pred = sum_ab[8:1];
            FILT_PAETH: pred = paeth;
            default:    pred = 8'd0;
        endcase
    end

    assign o_recon = i_op.filtered_byte + pred;

endmodule

/* rtl/core/png_row_unfilter_unit.sv */
// Top level of the image row unfilter block: line store, history and output stage.
//
// Reconstructs filtered image rows one byte per transfer and sustains one byte
// per clock while the output is not stalled. An accepted byte issues its line
// store read at the accept edge; in the next cycle the execute stage forms
// left/above/above-left and applies the row's filter (none, sub, up, average,
// Paeth, all modulo 256); when it can advance, it writes the result back to
// the line store at the same column and loads the output register.
// The single line store read per byte and its write-back set that rate; a
// byte that reads the column the previous byte is writing (a one-byte row, or
// bytes past the end of a maximum-length row) takes the value from a bypass
// register instead. The line store has no clearing pass and no valid bits:
// the first row after reset (or any column no earlier row reached) must be
// sent with above_is_zero set. Column position restarts after a byte marked
// last_in_row and saturates at the last store entry. bytes_per_pixel must be
// written on the config channel (always ready) only while no byte is in
// flight; the block itself does not enforce this. 0 acts as 1 and values
// above MAX_PIXEL_BYTES clamp.
module png_row_unfilter_unit #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  png_ru_pkg::t_in_item          i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output png_ru_pkg::t_out_item         o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [png_ru_pkg::BPP_W-1:0]  i_cfg_data
);
    import png_ru_pkg::*;

    localparam int COL_W  = $clog2(MAX_ROW_BYTES);
    localparam int PIX_IW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_ROW_BYTES - 1);
    localparam logic [BPP_W-1:0] BPP_MAX  = BPP_W'(MAX_PIXEL_BYTES);
    localparam logic [BPP_W-1:0] BPP_INIT =
        (BPP_RESET > MAX_PIXEL_BYTES) ? BPP_MAX : BPP_W'(BPP_RESET);

    // ---------------- configuration ----------------
    logic [BPP_W-1:0] r_bpp;     // already clamped to 1..MAX_PIXEL_BYTES
    logic [BPP_W-1:0] n_bpp;
    logic [BPP_W-1:0] tap;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_bpp = BPP_W'(1);
        end else if (i_cfg_data > BPP_MAX) begin
            n_bpp = BPP_MAX;
        end else begin
            n_bpp = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp <= BPP_INIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bpp <= n_bpp;
        end
    end

    assign tap = r_bpp - BPP_W'(1);

    // ---------------- handshake ----------------
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_fire;
    logic in_acc;

    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_acc     = i_in_valid && o_in_ready;

    // ---------------- column tracking ----------------
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;

    always_comb begin
        if (i_in_item.last_in_row) begin
            n_col = '0;
        end else if (r_col < COL_LAST) begin
            n_col = r_col + COL_W'(1);
        end else begin
            n_col = r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
        end
    end

    // ---------------- execute stage registers ----------------
    t_in_item         r_s1_item;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_first;   // still within the first pixel of the row
    logic             r_fwd;        // store read raced the previous write-back
    logic [7:0]       r_fwd_data;
    logic [7:0]       recon;
    logic [7:0]       ls_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item  <= i_in_item;
            r_s1_col   <= r_col;
            r_s1_first <= r_col < {{(COL_W-BPP_W){1'b0}}, r_bpp};
            r_fwd      <= s1_fire && (r_col == r_s1_col);
            r_fwd_data <= recon;
        end
    end

    png_ru_line_store #(
        .DEPTH  (MAX_ROW_BYTES),
        .ADDR_W (COL_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (ls_rdata),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_col),
        .i_wr_data (recon)
    );

    // ---------------- neighbor history ----------------
    logic [7:0] r_left  [MAX_PIXEL_BYTES];
    logic [7:0] r_upleft[MAX_PIXEL_BYTES];
    logic [7:0] above;
    t_pred_in   pred_op;

    assign above = r_s1_item.above_is_zero ? 8'd0 : (r_fwd ? r_fwd_data : ls_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]   <= 8'd0;
                r_upleft[i] <= 8'd0;
            end
        end else if (s1_fire) begin
            for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                r_left[i]   <= r_left[i-1];
                r_upleft[i] <= r_upleft[i-1];
            end
            r_left[0]   <= recon;
            r_upleft[0] <= above;
        end
    end

    assign pred_op.filtered_byte = r_s1_item.filtered_byte;
    assign pred_op.filter_type   = r_s1_item.filter_type;
    assign pred_op.left          = r_s1_first ? 8'd0 : r_left[tap[PIX_IW-1:0]];
    assign pred_op.above         = above;
    assign pred_op.above_left    = r_s1_first ? 8'd0 : r_upleft[tap[PIX_IW-1:0]];

    png_ru_predict u_predict (
        .i_op    (pred_op),
        .o_recon (recon)
    );

    // ---------------- output register ----------------
    t_out_item r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_item.recon_byte <= recon;
            r_out_item.row_done   <= r_s1_item.last_in_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ---------------- assertions ----------------
    a_col_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.last_in_row) |=> (r_col == '0))
        else $error("column did not restart after end of row");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_LAST)
        else $error("column beyond line store");

    a_bpp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bpp != '0) && (r_bpp <= BPP_MAX))
        else $error("pixel size out of range");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_valid))
        else $error("output loaded without an item in execute");

endmodule

/* tb/sv/png_row_unfilter_unit_tb.sv */
// Self-checking testbench for the image row unfilter block.
module png_row_unfilter_unit_tb;
    import png_ru_pkg::*;

    localparam int MAX_ROW      = 8192;
    localparam int MAX_PIX      = 8;
    localparam int RANDOM_BYTES = 1750;
    // ~2.4k bytes at most, then a 3x margin
    localparam int CYCLE_LIMIT  = 150000;

    // Filter codes the block treats as pass-through
    localparam logic [2:0] FILT_RSV5 = 3'd5;
    localparam logic [2:0] FILT_RSV6 = 3'd6;
    localparam logic [2:0] FILT_RSV7 = 3'd7;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_item;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [BPP_W-1:0]    i_cfg_data  = '0;

    png_row_unfilter_unit #(
        .MAX_ROW_BYTES   (MAX_ROW),
        .MAX_PIXEL_BYTES (MAX_PIX)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: mirror of the line store, the left / above-left
    // history and the column position, plus the pixel size register.
    // ------------------------------------------------------------------
    bit   [7:0]       line_mem    [MAX_ROW];
    bit               col_written [MAX_ROW];
    bit   [7:0]       left_pipe   [MAX_PIX];
    bit   [7:0]       upleft_pipe [MAX_PIX];
    int unsigned      cur_col     = 0;
    logic [BPP_W-1:0] pix_bytes   = BPP_RESET[BPP_W-1:0];

    t_out_item        pending_recon[$];   // expected bytes, oldest first
    int               fail_count  = 0;
    int               cycle_count = 0;
    int               burst_left  = 0;    // sender bytes left in this burst
    int               rx_mode     = 0;
    int               rx_left     = 0;

    // Directed steps; a typed step carries its expected byte, others use the predictor
    typedef struct {
        bit               is_cfg;
        logic [BPP_W-1:0] cfg_val;
        t_in_item         item;
        bit               typed;
        t_out_item        want;
    } t_dir_step;

    t_dir_step dir_steps[$];

    // Paeth: nearest of a, b, c to a+b-c; ties go to a, then b
    function automatic logic [7:0] paeth_choose(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c);
        int da, db, dc;
        da = int'(b) - int'(c);
        db = int'(a) - int'(c);
        dc = int'(a) + int'(b) - 2 * int'(c);
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc)
            return a;
        if (db <= dc)
            return b;
        return c;
    endfunction

    // Reconstructs one byte and advances the mirrored row state.
    function automatic t_out_item unfilter_byte(input t_in_item it);
        int unsigned pix;
        int unsigned col;
        logic [7:0]  left, up, upleft, guess, rb;
        t_out_item   res;
        // zero acts as one, oversize clamps to the widest pixel
        pix = (pix_bytes == 0) ? 1 : ((pix_bytes > MAX_PIX) ? MAX_PIX : pix_bytes);
        col = (cur_col > MAX_ROW - 1) ? MAX_ROW - 1 : cur_col;
        up     = it.above_is_zero ? 8'h00 : line_mem[col];
        left   = 8'h00;
        upleft = 8'h00;
        if (col >= pix) begin
            left   = left_pipe[pix-1];
            upleft = upleft_pipe[pix-1];
        end
        case (it.filter_type)
            FILT_SUB:   guess = left;
            FILT_UP:    guess = up;
            FILT_AVG:   guess = 8'((9'(left) + 9'(up)) >> 1);
            FILT_PAETH: guess = paeth_choose(left, up, upleft);
            default:    guess = 8'h00;
        endcase
        rb = it.filtered_byte + guess;
        line_mem[col]    = rb;
        col_written[col] = 1'b1;
        for (int i = MAX_PIX - 1; i > 0; i--) begin
            left_pipe[i]   = left_pipe[i-1];
            upleft_pipe[i] = upleft_pipe[i-1];
        end
        left_pipe[0]   = rb;
        upleft_pipe[0] = up;
        if (it.last_in_row)
            cur_col = 0;
        else if (col < MAX_ROW - 1)
            cur_col = col + 1;
        else
            cur_col = col;
        res.recon_byte = rb;
        res.row_done   = it.last_in_row;
        return res;
    endfunction

    // Sends one byte in bursts with random gaps; on transfer, queues the
    // typed expectation if given, else the predicted one.
    task automatic send_byte(input t_in_item it, input bit typed, input t_out_item want);
        int        gap;
        t_out_item pred;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk) i_in_valid <= 1'b0;
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        pred = unfilter_byte(it);
        pending_recon.push_back(typed ? want : pred);
    endtask

    // Register write only once the pipe has drained.
    task automatic write_pixel_bytes(input logic [BPP_W-1:0] v);
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_recon.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        pix_bytes = v;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
        burst_left = 0;
    endtask

    // One row; mixed rows change filter and above-zero flag byte by byte.
    // A column never reached by an earlier row is always sent with above zeroed.
    task automatic feed_row(input int unsigned width, input bit mixed, input bit flat_above);
        t_in_item   it;
        logic [2:0] ft;
        ft = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        for (int k = 0; k < width; k++) begin
            case ($urandom_range(0, 7))
                0:       it.filtered_byte = 8'h00;
                1:       it.filtered_byte = 8'hFF;
                2:       it.filtered_byte = 8'($urandom_range(0, 3));
                default: it.filtered_byte = 8'($urandom);
            endcase
            it.filter_type   = mixed ? 3'($urandom_range(0, 7)) : ft;
            it.last_in_row   = (k == width - 1);
            it.above_is_zero = mixed ? 1'($urandom_range(0, 1)) : flat_above;
            if (!col_written[cur_col])
                it.above_is_zero = 1'b1;
            send_byte(it, 1'b0, '0);
        end
    endtask

    task automatic dir_byte(input logic [7:0] fb, input logic [2:0] ft, input bit last,
                            input bit az, input bit typed, input logic [7:0] want_byte);
        t_dir_step s;
        s.is_cfg                = 1'b0;
        s.cfg_val               = '0;
        s.item.filtered_byte    = fb;
        s.item.filter_type      = ft;
        s.item.last_in_row      = last;
        s.item.above_is_zero    = az;
        s.typed                 = typed;
        s.want.recon_byte       = want_byte;
        s.want.row_done         = last;
        dir_steps.push_back(s);
    endtask

    task automatic dir_cfg(input logic [BPP_W-1:0] v);
        t_dir_step s;
        s         = '{default: '0};
        s.is_cfg  = 1'b1;
        s.cfg_val = v;
        dir_steps.push_back(s);
    endtask

    // Receiver: phases of always ready, mostly ready and mostly stalled.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(50, 300);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 3) != 0);
            default: i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Result check against the oldest expectation.
    always @(posedge i_clk) begin : check_out
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_recon.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected result: byte %02h row_done %0b",
                             o_out_item.recon_byte, o_out_item.row_done);
                fail_count++;
            end else begin
                want = pending_recon.pop_front();
                if (o_out_item.recon_byte !== want.recon_byte ||
                    o_out_item.row_done !== want.row_done) begin
                    if (fail_count < 10)
                        $display("mismatch: expected byte %02h row_done %0b, got %02h %0b",
                                 want.recon_byte, want.row_done,
                                 o_out_item.recon_byte, o_out_item.row_done);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stim
        int unsigned row_width;
        int unsigned rows;
        int          phase;
        int          bytes_sent;

        // First row after reset: above zeroed, every filter, extremes,
        // left and above-left zero for the first pixel, unknown filters.
        dir_byte(8'h00, FILT_NONE,  1'b0, 1'b1, 1'b1, 8'h00);
        dir_byte(8'hFF, FILT_SUB,   1'b0, 1'b1, 1'b1, 8'hFF);
        dir_byte(8'h80, FILT_UP,    1'b0, 1'b1, 1'b1, 8'h80);
        dir_byte(8'h7F, FILT_AVG,   1'b0, 1'b1, 1'b1, 8'h7F);
        dir_byte(8'h01, FILT_PAETH, 1'b0, 1'b1, 1'b0, 8'h00);
        dir_byte(8'hFF, FILT_SUB,   1'b0, 1'b1, 1'b0, 8'h00);   // wraps past 255
        dir_byte(8'h05, FILT_RSV5,  1'b0, 1'b1, 1'b1, 8'h05);
        dir_byte(8'hAA, FILT_RSV7,  1'b1, 1'b1, 1'b1, 8'hAA);
        // Second row reads the first one back from the line store
        dir_byte(8'h10, FILT_UP,    1'b0, 1'b0, 1'b0, 8'h00);
        dir_byte(8'h01, FILT_AVG,   1'b0, 1'b0, 1'b0, 8'h00);
        dir_byte(8'h80, FILT_PAETH, 1'b0, 1'b0, 1'b0, 8'h00);
        dir_byte(8'hFF, FILT_SUB,   1'b0, 1'b0, 1'b0, 8'h00);
        dir_byte(8'h33, FILT_RSV6,  1'b0, 1'b0, 1'b1, 8'h33);
        dir_byte(8'h00, FILT_PAETH, 1'b0, 1'b0, 1'b0, 8'h00);
        dir_byte(8'h7E, FILT_AVG,   1'b0, 1'b0, 1'b0, 8'h00);
        dir_byte(8'h55, FILT_UP,    1'b1, 1'b0, 1'b0, 8'h00);
        // One-byte rows: the second reads the column the first one writes
        dir_byte(8'h01, FILT_UP,    1'b1, 1'b0, 1'b0, 8'h00);
        dir_byte(8'hFF, FILT_UP,    1'b1, 1'b0, 1'b0, 8'h00);
        // Pixel size zero behaves as one byte
        dir_cfg(4'd0);
        dir_byte(8'h80, FILT_NONE,  1'b0, 1'b1, 1'b1, 8'h80);
        dir_byte(8'h90, FILT_SUB,   1'b0, 1'b1, 1'b0, 8'h00);
        dir_byte(8'h7F, FILT_PAETH, 1'b1, 1'b0, 1'b0, 8'h00);
        // Oversize pixel clamps to eight bytes
        dir_cfg(4'hF);
        dir_byte(8'hFF, FILT_SUB,   1'b0, 1'b0, 1'b1, 8'hFF);
        dir_byte(8'h01, FILT_AVG,   1'b0, 1'b0, 1'b0, 8'h00);
        dir_byte(8'h02, FILT_PAETH, 1'b1, 1'b0, 1'b0, 8'h00);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (dir_steps[i]) begin
            if (dir_steps[i].is_cfg)
                write_pixel_bytes(dir_steps[i].cfg_val);
            else
                send_byte(dir_steps[i].item, dir_steps[i].typed, dir_steps[i].want);
        end

        // Random images: each phase sets a pixel size, then sends rows of one width
        // (first row above-zero unless mixed), with a few ragged mixed rows that set
        // the width of later rows. Each register write waits for the pipe to drain.
        phase      = 0;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            case (phase)
                0:       write_pixel_bytes(4'd1);
                1:       write_pixel_bytes(4'd8);
                2:       write_pixel_bytes(4'd0);
                3:       write_pixel_bytes(4'hF);
                default: write_pixel_bytes(BPP_W'($urandom_range(0, 15)));
            endcase
            row_width = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4)
                                                    : $urandom_range(5, 48);
            rows = $urandom_range(3, 10);
            for (int r = 0; r < rows; r++) begin
                if ($urandom_range(0, 6) == 0) begin
                    row_width = $urandom_range(1, 60);
                    feed_row(row_width, 1'b1, 1'b0);
                end else begin
                    feed_row(row_width, 1'b0, (r == 0) || ($urandom_range(0, 9) == 0));
                end
                bytes_sent += row_width;
            end
            phase++;
        end

        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_recon.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* png_row_unfilter_unit.f */
rtl/core/png_ru_pkg.sv
rtl/core/png_ru_line_store.sv
rtl/core/png_ru_predict.sv
rtl/core/png_row_unfilter_unit.sv
tb/sv/png_row_unfilter_unit_tb.sv
